// ----- src/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and defaults for the indexed sequential search block:
// operation and status codes, fixed field widths and the default table geometry.
// ----------------------------------------------------------------------------
package iss_pkg;

  // default table geometry
  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefPageSize = 4;

  // fixed field widths
  localparam int unsigned KeyW    = 32;
  localparam int unsigned PosW    = 10;
  localparam int unsigned IdxCmpW = 9;
  localparam int unsigned PgCmpW  = 3;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DONE      = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

// ----- src/iss_ram.sv -----
// ----------------------------------------------------------------------------
// iss_ram
// Generic single-port synchronous RAM, one write or read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- src/indexed_sequential_search.sv -----
// ----------------------------------------------------------------------------
// indexed_sequential_search
// Keyed table with a page index: ascending loads, index walk or binary
// index search, then a scan of the chosen page.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Load and clear
// finish at once: their result strobes in the next cycle and busy stays low,
// so commands of that kind can follow back to back. A search raises busy and
// runs on the single-port key memory, whose read data is registered, so every
// key comparison takes a read state and a compare state. In walk mode the
// index entries are compared in order until one exceeds the target or none
// are left; the chosen page is then scanned, at most PAGE_SIZE keys, none
// when no page is chosen. In binary mode the index part makes at most
// floor(log2(pages)) + 1 probes. The result strobes in the same cycle that
// busy falls. Each result is presented for exactly one cycle on
// result_valid_o and must be taken then; the block never holds it. The key
// memory needs no clearing after reset. The user must write
// index_search_mode only while the block is idle; the block itself does not
// enforce it.
module indexed_sequential_search
  import iss_pkg::*;
#(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned PAGE_SIZE = DefPageSize
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                index_search_mode_we_i,
  input  logic                index_search_mode_i,
  // command
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [KeyW-1:0]     search_key_i,
  // result
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [PosW-1:0]     position_o,
  output logic [IdxCmpW-1:0]  index_compares_o,
  output logic [PgCmpW-1:0]   page_compares_o
);

  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned PagesMax = (CAPACITY + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int unsigned PGW      = $clog2(PagesMax + 1);
  localparam int unsigned ICW      = $clog2(PagesMax + 2);
  localparam int unsigned PCW      = $clog2(PAGE_SIZE + 1);
  localparam int unsigned OFW      = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_IDX  = 6'b000010,
    S_ICMP = 6'b000100,
    S_PSET = 6'b001000,
    S_PRD  = 6'b010000,
    S_PCMP = 6'b100000
  } state_e;

  // control state
  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [PGW-1:0] pages_q, pages_d;
  logic [OFW-1:0] off_q, off_d;
  logic           mode_q;
  logic           valid_q, valid_d;

  // search payload
  logic signed [KeyW-1:0] target_q, target_d;
  logic [PGW-1:0]  lo_q, lo_d;
  logic [PGW-1:0]  hi_q, hi_d;       // one past the last candidate entry
  logic [PGW-1:0]  pg_q, pg_d;       // index entry being probed
  logic [PGW-1:0]  chosen_q, chosen_d;
  logic [ICW-1:0]  icmp_q, icmp_d;
  logic [PCW-1:0]  pcmp_q, pcmp_d;
  logic [CW-1:0]   addr_q, addr_d;
  logic [CW-1:0]   end_q, end_d;
  status_e         status_q, status_d;
  logic [PosW-1:0] pos_q, pos_d;

  // memory port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [KeyW-1:0] ram_rdata;

  // helpers
  logic           accept;
  logic [PGW:0]   mid_sum;
  logic [PGW-1:0] mid;
  logic [PGW-1:0] probe;
  logic [CW-1:0]  base;
  logic [CW:0]    limit;
  logic           key_le;

  assign accept  = start && (state_q == S_IDLE);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (PGW + 1)'(1);
  assign mid     = mid_sum[PGW:1];
  assign probe   = mode_q ? mid : pg_q;
  assign base    = CW'((chosen_q - PGW'(1)) * PAGE_SIZE);
  assign limit   = {1'b0, base} + (CW + 1)'(PAGE_SIZE);
  assign key_le  = $signed(ram_rdata) <= target_q;

  iss_ram #(
    .Width(KeyW),
    .Depth(CAPACITY)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(search_key_i),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pages_d  = pages_q;
    off_d    = off_q;
    valid_d  = 1'b0;
    target_d = target_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    pg_d     = pg_q;
    chosen_d = chosen_q;
    icmp_d   = icmp_q;
    pcmp_d   = pcmp_q;
    addr_d   = addr_q;
    end_d    = end_q;
    status_d = status_q;
    pos_d    = pos_q;
    ram_we   = 1'b0;
    ram_addr = count_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            OP_LOAD: begin
              icmp_d  = '0;
              pcmp_d  = '0;
              valid_d = 1'b1;
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
                pos_d    = '0;
              end else begin
                ram_we   = 1'b1;
                status_d = ST_DONE;
                pos_d    = PosW'(count_q);
                count_d  = count_q + CW'(1);
                // a new page opens on its first record
                if (off_q == '0) begin
                  pages_d = pages_q + PGW'(1);
                end
                off_d = (off_q == OFW'(PAGE_SIZE - 1)) ? '0 : off_q + OFW'(1);
              end
            end
            OP_SEARCH: begin
              target_d = $signed(search_key_i);
              icmp_d   = mode_q ? '0 : ICW'(1);
              pcmp_d   = '0;
              chosen_d = '0;
              pg_d     = '0;
              lo_d     = '0;
              hi_d     = pages_q;
              state_d  = S_IDX;
            end
            OP_CLEAR: begin
              count_d  = '0;
              pages_d  = '0;
              off_d    = '0;
              icmp_d   = '0;
              pcmp_d   = '0;
              status_d = ST_DONE;
              pos_d    = '0;
              valid_d  = 1'b1;
            end
            default: begin
              // unused code: no transaction result
            end
          endcase
        end
      end

      // issue the next index probe or move on to the page
      S_IDX: begin
        ram_addr = AW'(probe * PAGE_SIZE);
        pg_d     = probe;
        if (mode_q ? (lo_q < hi_q) : (pg_q < pages_q)) begin
          state_d = S_ICMP;
        end else begin
          state_d = S_PSET;
        end
      end

      // compare the index key just read
      S_ICMP: begin
        if (mode_q) begin
          icmp_d  = icmp_q + ICW'(1);
          state_d = S_IDX;
          if (key_le) begin
            chosen_d = pg_q + PGW'(1);
            lo_d     = pg_q + PGW'(1);
          end else begin
            hi_d = pg_q;
          end
        end else if (key_le) begin
          chosen_d = pg_q + PGW'(1);
          icmp_d   = icmp_q + ICW'(1);
          pg_d     = pg_q + PGW'(1);
          state_d  = S_IDX;
        end else begin
          state_d = S_PSET;
        end
      end

      // bound the chosen page, the last one may be partial; no page means not found
      S_PSET: begin
        if (chosen_q == '0) begin
          status_d = ST_NOT_FOUND;
          pos_d    = '0;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          addr_d  = base;
          end_d   = (limit < {1'b0, count_q}) ? limit[CW-1:0] : count_q;
          state_d = S_PRD;
        end
      end

      // read the next record of the page, or report not found past its end
      S_PRD: begin
        ram_addr = addr_q[AW-1:0];
        if (addr_q < end_q) begin
          state_d = S_PCMP;
        end else begin
          status_d = ST_NOT_FOUND;
          pos_d    = '0;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // compare the record for equality
      S_PCMP: begin
        pcmp_d = pcmp_q + PCW'(1);
        if ($signed(ram_rdata) == target_q) begin
          status_d = ST_FOUND;
          pos_d    = PosW'(addr_q);
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          addr_d  = addr_q + CW'(1);
          state_d = S_PRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pages_q <= '0;
      off_q   <= '0;
      mode_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pages_q <= pages_d;
      off_q   <= off_d;
      valid_q <= valid_d;
      if (index_search_mode_we_i) begin
        mode_q <= index_search_mode_i;
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    pg_q     <= pg_d;
    chosen_q <= chosen_d;
    icmp_q   <= icmp_d;
    pcmp_q   <= pcmp_d;
    addr_q   <= addr_d;
    end_q    <= end_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  // outputs
  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign position_o       = pos_q;
  assign index_compares_o = IdxCmpW'(icmp_q);
  assign page_compares_o  = PgCmpW'(pcmp_q);

endmodule

// ----- src/iss_checker.sv -----
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks on command and result timing of the indexed sequential
// search block, bound to the top level.
// ----------------------------------------------------------------------------
module iss_checker
  import iss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [1:0]         status_o,
  input logic [IdxCmpW-1:0] index_compares_o,
  input logic [PgCmpW-1:0]  page_compares_o
);

  // a result never shows while a search is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // a result lasts one cycle unless a new transaction was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !(start && !busy) |=> !result_valid_o)
    else $error("result strobe held without a new transaction");

  // a search starts only from an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted transaction");

  // every result traces back to a transaction or a running search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy) || $past(busy))
    else $error("result without a transaction");

  // load and clear results carry no comparison counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == ST_DONE || status_o == ST_FULL)
      |-> index_compares_o == '0 && page_compares_o == '0)
    else $error("nonzero compare count on load or clear result");

endmodule

bind indexed_sequential_search iss_checker u_iss_checker (.*);
